// File: hdl/csem_pkg.sv
// ----------------------------------------------------------------------------
// Counting semaphore package
// Shared widths, command and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package csem_pkg;

   // Fixed field widths of the request and response.
   localparam int ID_BITS     = 4;
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 3;
   localparam int PERMIT_BITS = 16;

   // Defaults for the top-level parameters.
   localparam int DEF_CLIENTS    = 16;
   localparam int DEF_COUNT_BITS = 16;

   // Request commands. The fourth code is unused and reports as unknown.
   typedef enum logic [CMD_BITS-1:0] {
      CMD_ACQUIRE = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_DETACH  = 2'd2
   } cmd_type;

   // Response status codes.
   typedef enum logic [STATUS_BITS-1:0] {
      ST_GRANTED     = 3'd0,
      ST_QUEUED      = 3'd1,
      ST_DUP_HOLDER  = 3'd2,
      ST_DUP_WAITER  = 3'd3,
      ST_RELEASED    = 3'd4,
      ST_NOT_HOLDER  = 3'd5,
      ST_WAITER_GONE = 3'd6,
      ST_UNKNOWN     = 3'd7
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;    // register the incoming request
      logic execute;    // apply the held request and load the response
      logic cfg_write;  // reload the free-permit count
   } ctl_cmd_type;

endpackage

// File: hdl/csem_ctrl.sv
// ----------------------------------------------------------------------------
// Counting semaphore controller
// Sequences request capture, execution and response hand-off.
// ----------------------------------------------------------------------------
module csem_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   output csem_pkg::ctl_cmd_type ctl
);
   import csem_pkg::*;

   typedef enum logic {
      IDLE,
      BUSY
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      execute;
   logic      accept;

   // The held request executes once the response register is free or draining.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign execute    = (state_ff == BUSY) && out_free;
   assign req_tready = (state_ff == IDLE) || execute;
   assign accept     = req_tvalid && req_tready;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   assign ctl.capture   = accept;
   assign ctl.execute   = execute;
   assign ctl.cfg_write = csr_valid;

   assign rsp_tvalid = rsp_valid_ff;

   // Next state and response valid.
   always_comb begin
      state_in = state_ff;
      if (accept) begin
         state_in = BUSY;
      end else if (execute) begin
         state_in = IDLE;
      end
      rsp_valid_in = rsp_valid_ff;
      if (execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/csem_dp.sv
// ----------------------------------------------------------------------------
// Counting semaphore datapath
// Free count, holder and waiter bitmaps, compacting wait queue, response.
// ----------------------------------------------------------------------------
module csem_dp #(
   parameter int CLIENTS    = csem_pkg::DEF_CLIENTS,
   parameter int COUNT_BITS = csem_pkg::DEF_COUNT_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  csem_pkg::ctl_cmd_type            ctl,
   input  logic [csem_pkg::CMD_BITS-1:0]    req_command,
   input  logic [csem_pkg::ID_BITS-1:0]     req_client_id,
   input  logic [csem_pkg::PERMIT_BITS-1:0] csr_permits,
   output logic [csem_pkg::STATUS_BITS-1:0] rsp_status,
   output logic                             rsp_grant_valid,
   output logic [csem_pkg::ID_BITS-1:0]     rsp_grant_client
);
   import csem_pkg::*;

   localparam int LEN_BITS = $clog2(CLIENTS + 1);

   // Held request.
   cmd_type              cmd_ff;
   logic [ID_BITS-1:0]   client_ff;

   // Semaphore state.
   logic [COUNT_BITS-1:0] free_ff, free_in;
   logic [CLIENTS-1:0]    holder_ff, holder_in;
   logic [CLIENTS-1:0]    waiter_ff, waiter_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [ID_BITS-1:0]    queue_ff [CLIENTS];
   logic [ID_BITS-1:0]    queue_in [CLIENTS];

   // Response register.
   status_type           status_ff, status_in;
   logic                 gvalid_ff, gvalid_in;
   logic [ID_BITS-1:0]   gclient_ff, gclient_in;

   // Decode.
   logic               in_range;
   logic [CLIENTS-1:0] client_oh;
   logic [CLIENTS-1:0] head_oh;
   logic               is_holder;
   logic               is_waiter;
   logic               has_waiter;
   logic               grant_new;
   logic               do_queue;
   logic               do_release;
   logic               do_remove;
   logic               handoff;
   logic [CLIENTS-1:0] match;
   logic [CLIENTS-1:0] shift;

   assign in_range   = 32'(client_ff) < CLIENTS;
   assign client_oh  = in_range ? (CLIENTS'(1) << client_ff) : '0;
   assign head_oh    = CLIENTS'(1) << queue_ff[0];
   assign is_holder  = |(holder_ff & client_oh);
   assign is_waiter  = |(waiter_ff & client_oh);
   assign has_waiter = len_ff != '0;
   assign handoff    = do_release && has_waiter;

   // Position of the requesting client among the live queue entries.
   always_comb begin
      for (int i = 0; i < CLIENTS; i++) begin
         match[i] = (queue_ff[i] == client_ff) && (LEN_BITS'(i) < len_ff);
      end
   end

   // Command decision and status.
   always_comb begin
      grant_new  = 1'b0;
      do_queue   = 1'b0;
      do_release = 1'b0;
      do_remove  = 1'b0;
      status_in  = ST_UNKNOWN;
      if (in_range) begin
         case (cmd_ff)
            CMD_ACQUIRE: begin
               if (is_holder) begin
                  status_in = ST_DUP_HOLDER;
               end else if (is_waiter) begin
                  status_in = ST_DUP_WAITER;
               end else if (free_ff == '0) begin
                  status_in = ST_QUEUED;
                  do_queue  = 32'(len_ff) < CLIENTS;
               end else begin
                  status_in = ST_GRANTED;
                  grant_new = 1'b1;
               end
            end
            CMD_RELEASE: begin
               if (is_holder) begin
                  status_in  = ST_RELEASED;
                  do_release = 1'b1;
               end else begin
                  status_in = ST_NOT_HOLDER;
               end
            end
            CMD_DETACH: begin
               if (is_holder) begin
                  status_in  = ST_RELEASED;
                  do_release = 1'b1;
               end else if (is_waiter) begin
                  status_in = ST_WAITER_GONE;
                  do_remove = 1'b1;
               end
            end
            default: begin
               status_in = ST_UNKNOWN;
            end
         endcase
      end
   end

   // Grant notification.
   always_comb begin
      gvalid_in  = grant_new || handoff;
      gclient_in = '0;
      if (grant_new) begin
         gclient_in = client_ff;
      end else if (handoff) begin
         gclient_in = queue_ff[0];
      end
   end

   // Entries at and after the removed position move up by one.
   assign shift = handoff   ? '1 :
                  do_remove ? ~(match - CLIENTS'(1)) : '0;

   // Next state of the maps, count and queue.
   always_comb begin
      holder_in = holder_ff;
      waiter_in = waiter_ff;
      free_in   = free_ff;
      len_in    = len_ff;
      if (grant_new) begin
         holder_in = holder_ff | client_oh;
         free_in   = free_ff - COUNT_BITS'(1);
      end
      if (do_queue) begin
         waiter_in = waiter_ff | client_oh;
         len_in    = len_ff + LEN_BITS'(1);
      end
      if (do_release) begin
         if (has_waiter) begin
            holder_in = (holder_ff & ~client_oh) | head_oh;
            waiter_in = waiter_ff & ~head_oh;
            len_in    = len_ff - LEN_BITS'(1);
         end else begin
            holder_in = holder_ff & ~client_oh;
            if (free_ff != '1) begin
               free_in = free_ff + COUNT_BITS'(1);
            end
         end
      end
      if (do_remove) begin
         waiter_in = waiter_ff & ~client_oh;
         len_in    = len_ff - LEN_BITS'(1);
      end
      for (int i = 0; i < CLIENTS; i++) begin
         queue_in[i] = queue_ff[i];
         if (do_queue && (LEN_BITS'(i) == len_ff)) begin
            queue_in[i] = client_ff;
         end
      end
      for (int i = 0; i < CLIENTS - 1; i++) begin
         if (shift[i]) begin
            queue_in[i] = queue_ff[i + 1];
         end
      end
   end

   // Control state: count, maps and queue length.
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff   <= COUNT_BITS'(1);
         holder_ff <= '0;
         waiter_ff <= '0;
         len_ff    <= '0;
      end else if (ctl.cfg_write) begin
         free_ff <= COUNT_BITS'(csr_permits);
      end else if (ctl.execute) begin
         free_ff   <= free_in;
         holder_ff <= holder_in;
         waiter_ff <= waiter_in;
         len_ff    <= len_in;
      end
   end

   // Queue storage; entries beyond the length are never read.
   always_ff @(posedge clock) begin
      if (ctl.execute) begin
         queue_ff <= queue_in;
      end
   end

   // Request and response payload registers.
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff    <= cmd_type'(req_command);
         client_ff <= req_client_id;
      end
      if (ctl.execute) begin
         status_ff  <= status_in;
         gvalid_ff  <= gvalid_in;
         gclient_ff <= gclient_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_grant_valid  = gvalid_ff;
   assign rsp_grant_client = gclient_ff;

   // A client is never both a holder and a waiter.
   a_maps_disjoint: assert property (@(posedge clock) disable iff (reset)
      (holder_ff & waiter_ff) == '0)
      else $error("client is both holder and waiter");

   // The queue length tracks the number of waiters.
   a_len_matches_map: assert property (@(posedge clock) disable iff (reset)
      LEN_BITS'($countones(waiter_ff)) == len_ff)
      else $error("queue length differs from waiter count");

   // A grant only accompanies a granted or released status.
   a_grant_status: assert property (@(posedge clock) disable iff (reset)
      ctl.execute && gvalid_in |-> status_in == ST_GRANTED || status_in == ST_RELEASED)
      else $error("grant with unexpected status");

   // A handoff never changes the free count.
   a_handoff_count: assert property (@(posedge clock) disable iff (reset)
      ctl.execute && handoff && !ctl.cfg_write |=> $stable(free_ff))
      else $error("free count moved on handoff");

endmodule

// File: hdl/counting_semaphore_fifo_waiters.sv
// ----------------------------------------------------------------------------
// Counting semaphore with FIFO waiters
// Top level: controller and datapath of a permit semaphore for fixed clients.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the req_ stream: tuser carries the command (acquire,
//   release, detach) and tdata the client id. Each request yields exactly one
//   response on the rsp_ stream with a status, a grant flag and the client
//   that receives the grant (zero when there is none).
//   The csr_ channel loads a new free-permit count; write it only while no
//   request is outstanding. Writes are always accepted. An accepted request
//   is held in the request register and executes once the response register
//   is free or draining; the response turns valid as it is loaded. A new
//   request is taken in the same cycle the held one executes, so one
//   request per cycle is sustained while the response side keeps up; the
//   single held request register and the response register set that figure.
//   A stalled response holds in its register; one further request is taken
//   and held, after which req_tready stays low until the response drains.
//   Reset clears the holder and waiter sets, empties the queue and sets the
//   free count to one.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters #(
   parameter int CLIENTS    = csem_pkg::DEF_CLIENTS,
   parameter int COUNT_BITS = csem_pkg::DEF_COUNT_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,  // [3:0] client_id, [7:4] zero
   input  logic [csem_pkg::CMD_BITS-1:0]    req_tuser,  // [1:0] command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,  // [3:0] grant_client, [7:4] zero
   output logic [3:0]                       rsp_tuser,  // [2:0] status, [3] grant_valid
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [csem_pkg::PERMIT_BITS-1:0] csr_data    // permits
);
   import csem_pkg::*;

   ctl_cmd_type            ctl;
   logic [STATUS_BITS-1:0] status;
   logic                   grant_valid;
   logic [ID_BITS-1:0]     grant_client;

   // Handshake sequencing.
   csem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .ctl        (ctl)
   );

   // Semaphore state and response.
   csem_dp #(
      .CLIENTS    (CLIENTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_command      (req_tuser),
      .req_client_id    (req_tdata[ID_BITS-1:0]),
      .csr_permits      (csr_data),
      .rsp_status       (status),
      .rsp_grant_valid  (grant_valid),
      .rsp_grant_client (grant_client)
   );

   // Response packing.
   assign rsp_tdata = {{(8 - ID_BITS){1'b0}}, grant_client};
   assign rsp_tuser = {grant_valid, status};

endmodule

// File: sim/counting_semaphore_fifo_waiters_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore with FIFO waiters: testbench
// Drives acquire, release and detach requests into the semaphore. A local
// model of the permit count, holder and waiter sets and the wait queue
// predicts each response, and every response is checked field by field in
// order. Directed cases run first, then random traffic under three mixes
// of sender and receiver stalls, with the permit count reloaded in between.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_tb;
   import csem_pkg::*;

   // The fourth command code, which the block reports as unknown.
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam logic [PERMIT_BITS-1:0] PERMITS_MAX = 16'hFFFF;
   localparam int DRAIN_CYCLES = 6;

   // One predicted response.
   typedef struct packed {
      status_type          status;
      logic                grant;
      logic [ID_BITS-1:0]  grant_id;
   } grant_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = '0;
   logic [CMD_BITS-1:0]    req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic [3:0]             rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [PERMIT_BITS-1:0] csr_data = '0;

   // Model of the semaphore state.
   logic [15:0]            free_permits;
   logic [15:0]            holders;
   logic [15:0]            waiters;
   logic [ID_BITS-1:0]     wait_line[$];

   grant_result_type       pending_results[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   int n_requests = 0;
   int n_responses = 0;
   int n_grants = 0;
   int n_permit_writes = 0;

   counting_semaphore_fifo_waiters dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hand a released permit to the oldest waiter, or return it to the pool.
   function automatic grant_result_type release_permit(logic [ID_BITS-1:0] id);
      grant_result_type r;
      logic [ID_BITS-1:0] next_id;
      r = '{status: ST_RELEASED, grant: 1'b0, grant_id: '0};
      holders[id] = 1'b0;
      if (wait_line.size() > 0) begin
         next_id = wait_line.pop_front();
         waiters[next_id] = 1'b0;
         holders[next_id] = 1'b1;
         r.grant = 1'b1;
         r.grant_id = next_id;
      end else if (free_permits < PERMITS_MAX) begin
         free_permits = free_permits + 1'b1;
      end
      return r;
   endfunction

   // Apply one accepted request to the model and return the expected response.
   function automatic grant_result_type apply_request(logic [CMD_BITS-1:0] cmd,
                                                      logic [ID_BITS-1:0] id);
      grant_result_type r;
      r = '{status: ST_UNKNOWN, grant: 1'b0, grant_id: '0};
      if (cmd == CMD_ACQUIRE) begin
         if (holders[id]) begin
            r.status = ST_DUP_HOLDER;
         end else if (waiters[id]) begin
            r.status = ST_DUP_WAITER;
         end else if (free_permits == 0) begin
            wait_line = {wait_line, id};
            waiters[id] = 1'b1;
            r.status = ST_QUEUED;
         end else begin
            free_permits = free_permits - 1'b1;
            holders[id] = 1'b1;
            r = '{status: ST_GRANTED, grant: 1'b1, grant_id: id};
         end
      end else if (cmd == CMD_RELEASE) begin
         if (holders[id]) r = release_permit(id);
         else r.status = ST_NOT_HOLDER;
      end else if (cmd == CMD_DETACH) begin
         if (holders[id]) begin
            r = release_permit(id);
         end else if (waiters[id]) begin
            foreach (wait_line[i]) begin
               if (wait_line[i] == id) begin
                  wait_line.delete(i);
                  break;
               end
            end
            waiters[id] = 1'b0;
            r.status = ST_WAITER_GONE;
         end
      end
      return r;
   endfunction

   // Print one mismatch line and count it.
   task automatic report_mismatch(string what, int got, int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   // Send one request, with random idle cycles ahead of it when asked.
   task automatic send_request(logic [CMD_BITS-1:0] cmd, logic [ID_BITS-1:0] id);
      grant_result_type want;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, id};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      want = apply_request(cmd, id);
      pending_results = {pending_results, want};
      n_requests++;
   endtask

   // Stop sending and wait for every outstanding response.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Load a new free-permit count while the block is idle.
   task automatic write_permits(logic [PERMIT_BITS-1:0] value);
      drain_responses();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      free_permits = value;
      n_permit_writes++;
   endtask

   // Random member of a client set, which must not be empty.
   function automatic logic [ID_BITS-1:0] pick_member(logic [15:0] set);
      int k;
      k = $urandom_range(0, $countones(set) - 1);
      for (int i = 0; i < 16; i++) begin
         if (set[i]) begin
            if (k == 0) return i[ID_BITS-1:0];
            k--;
         end
      end
      return '0;
   endfunction

   // Mostly small permit counts so that queues build up, sometimes extremes.
   function automatic logic [PERMIT_BITS-1:0] choose_permits();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return PERMITS_MAX;
      if (r == 1) return PERMITS_MAX - 1'b1;
      if (r == 2) return PERMIT_BITS'($urandom_range(0, 65535));
      return PERMIT_BITS'($urandom_range(0, 4));
   endfunction

   // Basic grant, queue, duplicate, release, detach and unknown-command behavior from reset.
   task automatic test_directed();
      send_request(CMD_ACQUIRE, 4'd0);
      send_request(CMD_ACQUIRE, 4'd1);
      send_request(CMD_ACQUIRE, 4'd0);
      send_request(CMD_ACQUIRE, 4'd1);
      send_request(CMD_RELEASE, 4'd2);
      send_request(CMD_RELEASE, 4'd0);
      send_request(CMD_RELEASE, 4'd1);
      send_request(CMD_DETACH, 4'd3);
      send_request(CMD_UNUSED, 4'd5);
      send_request(CMD_ACQUIRE, 4'd15);
      send_request(CMD_ACQUIRE, 4'd14);
      send_request(CMD_ACQUIRE, 4'd13);
      send_request(CMD_ACQUIRE, 4'd12);
      // Remove a waiter from the middle of the line.
      send_request(CMD_DETACH, 4'd13);
      // Detaching holders passes the permit down the line.
      send_request(CMD_DETACH, 4'd15);
      send_request(CMD_DETACH, 4'd14);
      send_request(CMD_DETACH, 4'd12);
      drain_responses();
   endtask

   // Full and empty permit counts, including release into a saturated count.
   task automatic test_permit_extremes();
      send_request(CMD_ACQUIRE, 4'd7);
      write_permits(PERMITS_MAX);
      send_request(CMD_RELEASE, 4'd7);
      send_request(CMD_ACQUIRE, 4'd8);
      write_permits('0);
      send_request(CMD_ACQUIRE, 4'd9);
      send_request(CMD_ACQUIRE, 4'd10);
      send_request(CMD_RELEASE, 4'd8);
      send_request(CMD_DETACH, 4'd10);
      send_request(CMD_DETACH, 4'd9);
      drain_responses();
   endtask

   // Random traffic; releases and detaches are aimed at holders and waiters most of the time.
   task automatic test_random_traffic(int send_pct, int recv_pct, int items);
      int r;
      logic [ID_BITS-1:0] id;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < items; n++) begin
         if (n % 100 == 0) write_permits(choose_permits());
         id = ID_BITS'($urandom_range(0, 15));
         r = $urandom_range(0, 99);
         if (r < 45) begin
            send_request(CMD_ACQUIRE, id);
         end else if (r < 70) begin
            if (holders != 0 && $urandom_range(0, 3) != 0) id = pick_member(holders);
            send_request(CMD_RELEASE, id);
         end else if (r < 95) begin
            if (waiters != 0 && $urandom_range(0, 1) != 0) id = pick_member(waiters);
            else if (holders != 0 && $urandom_range(0, 1) != 0) id = pick_member(holders);
            send_request(CMD_DETACH, id);
         end else begin
            send_request(CMD_UNUSED, id);
         end
      end
      drain_responses();
   endtask

   // Receiver stalls and the response check.
   always @(posedge clock) begin
      grant_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_responses++;
         if (pending_results.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser[2:0] != want.status)
               report_mismatch("status", rsp_tuser[2:0], want.status);
            if (rsp_tuser[3] != want.grant)
               report_mismatch("grant_valid", rsp_tuser[3], want.grant);
            if (rsp_tdata[3:0] != want.grant_id)
               report_mismatch("grant_client", rsp_tdata[3:0], want.grant_id);
            if (want.grant) n_grants++;
         end
      end
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Test sequence.
   initial begin
      free_permits = 16'd1;
      holders = '0;
      waiters = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_permit_extremes();
      test_random_traffic(26, 85, 500);
      test_random_traffic(85, 26, 500);
      test_random_traffic(0, 0, 500);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d requests and checked %0d responses, %0d of them grants.",
               n_requests, n_responses, n_grants);
      $display("Permit count reloaded %0d times, under three sender/receiver stall mixes.",
               n_permit_writes);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("PASS counting_semaphore_fifo_waiters");
      end else begin
         $display("FAIL counting_semaphore_fifo_waiters");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #5_000_000;
      $display("Timed out with %0d responses outstanding.", pending_results.size());
      $display("FAIL counting_semaphore_fifo_waiters");
      $finish;
   end

endmodule
